@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files of the row span block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rrs_pkg.sv @@
// Package of the rounded rectangle row span block: register indexes
// and reset values of the configuration registers. Depends on nothing.
`default_nettype none

package rrs_pkg;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RECT_WIDTH    = 2'd0,
      CSR_RECT_HEIGHT   = 2'd1,
      CSR_CORNER_RADIUS = 2'd2
   } csr_index_type;

   localparam int unsigned RST_RECT_WIDTH    = 220;
   localparam int unsigned RST_RECT_HEIGHT   = 44;
   localparam int unsigned RST_CORNER_RADIUS = 352;

endpackage

`default_nettype wire

@@ src/rrs_front.sv @@
// First stage: clamps the radius, places the row centre and finds its
// distance into a corner band. Depends on nothing but its ports.
`default_nettype none

module rrs_front #(
   parameter int DIM_BITS  = 12,
   parameter int FRAC_BITS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          in_valid,
   input  wire logic [DIM_BITS-1:0]           row_index,
   input  wire logic [DIM_BITS-1:0]           rect_width,
   input  wire logic [DIM_BITS-1:0]           rect_height,
   input  wire logic [DIM_BITS+FRAC_BITS-1:0] corner_radius,
   output logic                               out_valid,
   output logic [DIM_BITS-1:0]                row_ff,
   output logic                               row_valid_ff,
   output logic [DIM_BITS-1:0]                width_ff,
   output logic [DIM_BITS+FRAC_BITS-1:0]      radius_ff,
   output logic [DIM_BITS+FRAC_BITS-1:0]      dist_ff
);

   localparam int RW = DIM_BITS + FRAC_BITS;
   localparam logic [RW-1:0] HALF_UNIT = RW'(1) << (FRAC_BITS - 1);

   logic          valid_ff;
   logic [DIM_BITS-1:0] width_in, height_eff;
   logic [RW-1:0] height_q, half_q, radius_in, centre, lower, dist_raw, dist_in;
   logic          in_top, in_bottom, row_valid_in;

   always_comb begin
      width_in     = (rect_width == '0) ? DIM_BITS'(1) : rect_width;
      height_eff   = (rect_height == '0) ? DIM_BITS'(1) : rect_height;
      height_q     = {height_eff, FRAC_BITS'(0)};
      half_q       = height_q >> 1;
      radius_in    = (corner_radius > half_q) ? half_q : corner_radius;
      centre       = {row_index, FRAC_BITS'(0)} | HALF_UNIT;
      lower        = height_q - radius_in;
      in_top       = centre < radius_in;
      in_bottom    = centre > lower;
      if (in_top) begin
         dist_raw = radius_in - centre;
      end else if (in_bottom) begin
         dist_raw = centre - lower;
      end else begin
         dist_raw = '0;
      end
      dist_in      = (dist_raw > radius_in) ? radius_in : dist_raw;
      row_valid_in = row_index < height_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         row_ff       <= row_index;
         row_valid_ff <= row_valid_in;
         width_ff     <= width_in;
         radius_ff    <= radius_in;
         dist_ff      <= dist_in;
      end
   end

   assign out_valid = valid_ff;

endmodule

`default_nettype wire

@@ src/rrs_square.sv @@
// Two stages: squares radius and distance, then forms r*r - d*d.
// Depends on nothing but its ports; side data rides along unchanged.
`default_nettype none

module rrs_square #(
   parameter int RW     = 16,
   parameter int SIDE_W = 41
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [RW-1:0]     radius,
   input  wire logic [RW-1:0]     distance,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [2*RW-1:0]        radicand_ff,
   output logic [SIDE_W-1:0]      out_side
);

   logic [1:0]        valid_ff;
   logic [2*RW-1:0]   rsq_ff, dsq_ff, rsq_in, dsq_in, radicand_in;
   logic [SIDE_W-1:0] side_a_ff, side_b_ff;

   assign rsq_in      = radius * radius;
   assign dsq_in      = distance * distance;
   assign radicand_in = rsq_ff - dsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsq_ff      <= rsq_in;
         dsq_ff      <= dsq_in;
         side_a_ff   <= in_side;
         radicand_ff <= radicand_in;
         side_b_ff   <= side_a_ff;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_side  = side_b_ff;

endmodule

`default_nettype wire

@@ src/rrs_isqrt.sv @@
// Pipelined integer square root, floor of sqrt of a 2*RW bit radicand,
// one result bit per stage. Depends on nothing but its ports.
`default_nettype none

module rrs_isqrt #(
   parameter int RW     = 16,
   parameter int SIDE_W = 41
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [2*RW-1:0]   radicand,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [RW-1:0]          root,
   output logic [SIDE_W-1:0]      out_side
);

   logic [RW-1:0]     valid_ff, valid_in;
   logic [2*RW-1:0]   rad_ff  [RW];
   logic [2*RW-1:0]   rad_in  [RW];
   logic [RW+1:0]     rem_ff  [RW];
   logic [RW+1:0]     rem_in  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [RW-1:0]     root_in [RW];
   logic [SIDE_W-1:0] side_ff [RW];
   logic [SIDE_W-1:0] side_in [RW];

   for (genvar g = 0; g < RW; g++) begin : g_stage
      logic              v_src;
      logic [2*RW-1:0]   rad_src;
      logic [RW+1:0]     rem_src, rem_sh, trial;
      logic [RW-1:0]     root_src;
      logic [SIDE_W-1:0] side_src;
      logic              fit;

      if (g == 0) begin : g_first
         assign v_src    = in_valid;
         assign rad_src  = radicand;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[g-1];
         assign rad_src  = rad_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      // remainder stays below 2^RW ahead of the shift
      assign rem_sh      = {rem_src[RW-1:0], rad_src[2*RW-1 -: 2]};
      assign trial       = {root_src, 2'b01};
      assign fit         = rem_sh >= trial;
      assign rem_in[g]   = fit ? (rem_sh - trial) : rem_sh;
      assign root_in[g]  = {root_src[RW-2:0], fit};
      assign rad_in[g]   = {rad_src[2*RW-3:0], 2'b00};
      assign side_in[g]  = side_src;
      assign valid_in[g] = v_src;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < RW; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

@@ src/rrs_back.sv @@
// Last two stages: inset to start column, then span width and the
// output register. Depends on nothing but its ports.
`default_nettype none

module rrs_back #(
   parameter int DIM_BITS  = 12,
   parameter int FRAC_BITS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          in_valid,
   input  wire logic [DIM_BITS+FRAC_BITS-1:0] root,
   input  wire logic [DIM_BITS+FRAC_BITS-1:0] radius,
   input  wire logic [DIM_BITS-1:0]           row,
   input  wire logic                          row_valid,
   input  wire logic [DIM_BITS-1:0]           width,
   output logic                               out_valid,
   output logic [DIM_BITS-1:0]                row_number_ff,
   output logic [DIM_BITS-2:0]                span_start_ff,
   output logic [DIM_BITS-1:0]                span_width_ff,
   output logic                               row_valid_ff
);

   localparam int RW = DIM_BITS + FRAC_BITS;

   logic [1:0]          valid_ff;
   logic [RW-1:0]       root_eff, inset, inset_px;
   logic [DIM_BITS-2:0] start_ff, start_in, span_start_in;
   logic [DIM_BITS-1:0] row_a_ff, width_a_ff, twice, span_width_in;
   logic                row_valid_a_ff;

   always_comb begin
      root_eff = (root > radius) ? radius : root;
      inset    = radius - root_eff;
      inset_px = inset >> FRAC_BITS;
      start_in = inset_px[DIM_BITS-2:0];
   end

   always_comb begin
      twice = {start_ff, 1'b0};
      if (!row_valid_a_ff) begin
         span_start_in = '0;
         span_width_in = '0;
      end else begin
         span_start_in = start_ff;
         span_width_in = (twice < width_a_ff) ? (width_a_ff - twice) : DIM_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         start_ff       <= start_in;
         row_a_ff       <= row;
         width_a_ff     <= width;
         row_valid_a_ff <= row_valid;
         row_number_ff  <= row_a_ff;
         span_start_ff  <= span_start_in;
         span_width_ff  <= span_width_in;
         row_valid_ff   <= row_valid_a_ff;
      end
   end

   assign out_valid = valid_ff[1];

endmodule

`default_nettype wire

@@ src/rounded_rect_row_spans.sv @@
// Rounded rectangle row spans: for each row index, the first covered
// column and covered width of that row of a rounded rectangle.
// Depends on rrs_pkg, assert_macros.svh, rrs_front, rrs_square, rrs_isqrt, rrs_back.
//
// Request channel req_* carries a row index, result channel rsp_* the
// echoed row, span start, span width and row_valid. An item moves at a
// clock edge where valid is high and stall is low.
// The pipeline holds one stage of band geometry, two of squaring,
// one per root bit in the square root pipeline and two for the span.
// One row enters every cycle unless the pipeline is frozen.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall is raised; nothing is lost or repeated.
// Reset empties the pipeline and loads width 220, height 44 and radius
// 352 (22 pixels). Write csr_* only while no item is in flight; the
// registers are sampled as a row enters.
`default_nettype none

`include "assert_macros.svh"

module rounded_rect_row_spans
   import rrs_pkg::*;
#(
   parameter int DIM_BITS  = 12,
   parameter int FRAC_BITS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [DIM_BITS-1:0]           req_row_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [DIM_BITS-1:0]                rsp_row_number,
   output logic [DIM_BITS-2:0]                rsp_span_start,
   output logic [DIM_BITS-1:0]                rsp_span_width,
   output logic                               rsp_row_valid,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [DIM_BITS+FRAC_BITS-1:0] csr_wdata
);

   localparam int RW     = DIM_BITS + FRAC_BITS;
   localparam int SIDE_W = 2 * DIM_BITS + RW + 1;

   logic [DIM_BITS-1:0] width_ff, height_ff;
   logic [RW-1:0]       radius_ff;
   logic                advance;

   logic                f_valid, f_row_valid;
   logic [DIM_BITS-1:0] f_row, f_width;
   logic [RW-1:0]       f_radius, f_dist;
   logic [SIDE_W-1:0]   f_side, q_side, s_side;
   logic                q_valid, s_valid;
   logic [2*RW-1:0]     q_radicand;
   logic [RW-1:0]       s_root;
   logic                outside_ok, inside_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(RST_RECT_WIDTH);
         height_ff <= DIM_BITS'(RST_RECT_HEIGHT);
         radius_ff <= RW'(RST_CORNER_RADIUS);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RECT_WIDTH:    width_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_RECT_HEIGHT:   height_ff <= csr_wdata[DIM_BITS-1:0];
            CSR_CORNER_RADIUS: radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   rrs_front #(
      .DIM_BITS  (DIM_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .in_valid      (req_valid),
      .row_index     (req_row_index),
      .rect_width    (width_ff),
      .rect_height   (height_ff),
      .corner_radius (radius_ff),
      .out_valid     (f_valid),
      .row_ff        (f_row),
      .row_valid_ff  (f_row_valid),
      .width_ff      (f_width),
      .radius_ff     (f_radius),
      .dist_ff       (f_dist)
   );

   assign f_side = {f_row, f_row_valid, f_width, f_radius};

   rrs_square #(
      .RW     (RW),
      .SIDE_W (SIDE_W)
   ) u_square (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .in_valid    (f_valid),
      .radius      (f_radius),
      .distance    (f_dist),
      .in_side     (f_side),
      .out_valid   (q_valid),
      .radicand_ff (q_radicand),
      .out_side    (q_side)
   );

   rrs_isqrt #(
      .RW     (RW),
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (q_valid),
      .radicand  (q_radicand),
      .in_side   (q_side),
      .out_valid (s_valid),
      .root      (s_root),
      .out_side  (s_side)
   );

   rrs_back #(
      .DIM_BITS  (DIM_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .in_valid      (s_valid),
      .root          (s_root),
      .radius        (s_side[RW-1:0]),
      .row           (s_side[SIDE_W-1 -: DIM_BITS]),
      .row_valid     (s_side[RW+DIM_BITS]),
      .width         (s_side[RW +: DIM_BITS]),
      .out_valid     (rsp_valid),
      .row_number_ff (rsp_row_number),
      .span_start_ff (rsp_span_start),
      .span_width_ff (rsp_span_width),
      .row_valid_ff  (rsp_row_valid)
   );

   assign outside_ok = !rsp_valid || rsp_row_valid
                       || (rsp_span_start == '0 && rsp_span_width == '0);
   assign inside_ok  = !rsp_valid || !rsp_row_valid || rsp_span_width != '0;

   `ASSERT_RUN(a_outside_zero, clock, reset, outside_ok, "row outside height carries a span")
   `ASSERT_RUN(a_inside_width, clock, reset, inside_ok, "row inside height has zero width")
   `ASSERT_ALL(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for rounded_rect_row_spans: rows are sent under random gaps and stalls,
// and each span is checked against a span predictor kept inside the bench.
// Depends on rrs_pkg and the rounded_rect_row_spans RTL.
module testbench;
   import rrs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_BITS    = 12;
   localparam int FRAC_BITS   = 4;
   localparam int LATENCY     = DIM_BITS + FRAC_BITS + 5;
   localparam int CYCLE_LIMIT = 300000;
   localparam int REPORT_MAX  = 10;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [DIM_BITS-1:0] row_number;
      logic [DIM_BITS-2:0] span_start;
      logic [DIM_BITS-1:0] span_width;
      logic                row_valid;
   } row_span_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [DIM_BITS-1:0] req_row_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DIM_BITS-1:0] rsp_row_number;
   logic [DIM_BITS-2:0] rsp_span_start;
   logic [DIM_BITS-1:0] rsp_span_width;
   logic rsp_row_valid;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_RECT_WIDTH;
   logic [DIM_BITS+FRAC_BITS-1:0] csr_wdata = '0;

   logic [DIM_BITS-1:0] shape_width = DIM_BITS'(RST_RECT_WIDTH);
   logic [DIM_BITS-1:0] shape_height = DIM_BITS'(RST_RECT_HEIGHT);
   logic [DIM_BITS+FRAC_BITS-1:0] shape_radius = (DIM_BITS+FRAC_BITS)'(RST_CORNER_RADIUS);

   row_span_type expected_spans[$];
   int mismatches = 0;
   int cycle_count = 0;
   int gap_max = 7;
   int stall_max = 7;
   int stall_left = 0;

   rounded_rect_row_spans #(
      .DIM_BITS (DIM_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row_index (req_row_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_row_number(rsp_row_number),
      .rsp_span_start(rsp_span_start),
      .rsp_span_width(rsp_span_width),
      .rsp_row_valid (rsp_row_valid),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic row_span_type predict_span(logic [DIM_BITS-1:0] row);
      row_span_type span;
      longint unsigned w, h, hq, r, c, d, s, trial, start;
      bit band;
      w = (shape_width == 0) ? 1 : shape_width;
      h = (shape_height == 0) ? 1 : shape_height;
      hq = h << FRAC_BITS;
      r = shape_radius;
      span = '0;
      span.row_number = row;
      if (longint'(row) >= h)
         return span;
      if (r > hq / 2)
         r = hq / 2;
      // row center sits half a pixel below the row's top edge
      c = (longint'(row) << FRAC_BITS) + (64'd1 << (FRAC_BITS - 1));
      band = 1'b1;
      d = 0;
      if (c < r)
         d = r - c;
      else if (c > hq - r)
         d = c - (hq - r);
      else
         band = 1'b0;
      start = 0;
      if (band) begin
         s = 0;
         for (int b = DIM_BITS + FRAC_BITS - 1; b >= 0; b--) begin
            trial = s | (64'd1 << b);
            if (trial * trial <= r * r - d * d)
               s = trial;
         end
         start = (r - s) >> FRAC_BITS;
      end
      span.span_start = start[DIM_BITS-2:0];
      span.span_width = DIM_BITS'((2 * start < w) ? w - 2 * start : 1);
      span.row_valid = 1'b1;
      return span;
   endfunction

   always @(posedge clock) begin
      row_span_type got, want;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_row_number, rsp_span_start, rsp_span_width, rsp_row_valid};
            if (expected_spans.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected span: row %0d start %0d width %0d valid %0b",
                     got.row_number, got.span_start, got.span_width, got.row_valid);
            end else begin
               want = expected_spans.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("span mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                        want.row_number, want.span_start, want.span_width, want.row_valid,
                        got.row_number, got.span_start, got.span_width, got.row_valid);
               end
            end
            stall_left = $urandom_range(0, stall_max);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   task automatic send_row(input logic [DIM_BITS-1:0] row);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_row_index <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_spans = {expected_spans, predict_span(row)};
   endtask

   // Drain in-flight rows, then write every register plus the unmapped index.
   task automatic program_shape(input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] r);
      req_valid <= 1'b0;
      while (expected_spans.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_RECT_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_RECT_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= (DIM_BITS+FRAC_BITS)'($urandom);
      @(posedge clock);
      csr_index <= CSR_CORNER_RADIUS;
      csr_wdata <= r;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shape_width = w[DIM_BITS-1:0];
      shape_height = h[DIM_BITS-1:0];
      shape_radius = r;
   endtask

   task automatic test_reset_shape();
      send_row(0);
      send_row(21);
      send_row(43);
      send_row(44);
      send_row(4095);
   endtask

   task automatic test_register_extremes();
      // radius far above half height gets clamped
      program_shape(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_row(0);
      send_row(2047);
      send_row(4094);
      send_row(4095);
      // zero width and height behave as one pixel
      program_shape(16'h0000, 16'h0000, 16'h0000);
      send_row(0);
      send_row(1);
      // upper data bits beyond the register width are dropped
      program_shape(16'hF00A, 16'h0008, 16'hFFFF);
      send_row(0);
      send_row(3);
      send_row(7);
   endtask

   task automatic test_narrow_spans();
      program_shape(16'd3, 16'd40, 16'd320);
      send_row(0);
      send_row(1);
      send_row(20);
      program_shape(16'd1000, 16'd100, 16'd0);
      send_row(0);
      send_row(99);
   endtask

   task automatic test_random_shapes();
      logic [15:0] w, h, r;
      int h_eff, band_rows, pick;
      logic [DIM_BITS-1:0] row;
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 5))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w = 16'($urandom);
            default: w = 16'($urandom_range(1, 300));
         endcase
         case ($urandom_range(0, 5))
            0: h = 16'($urandom);
            1: h = 16'($urandom_range(1, 4));
            2: h = 16'd4095;
            3: h = 16'($urandom_range(1, 4095));
            default: h = 16'($urandom_range(1, 120));
         endcase
         h_eff = (h[DIM_BITS-1:0] == 0) ? 1 : int'(h[DIM_BITS-1:0]);
         case ($urandom_range(0, 5))
            0: r = 16'h0000;
            1: r = 16'($urandom);
            2: r = 16'(h_eff * 8);
            3: r = 16'(h_eff * 8 + int'($urandom_range(1, 100)));
            default: r = 16'($urandom_range(0, h_eff * 8));
         endcase
         program_shape(w, h, r);
         gap_max = (phase % 4 == 0) ? 0 : 7;
         stall_max = (phase % 3 == 0) ? 0 : 7;
         band_rows = ((r > h_eff * 8) ? h_eff * 8 : int'(r)) / 16 + 1;
         if (band_rows > h_eff - 1)
            band_rows = h_eff - 1;
         for (int n = 0; n < 96; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               row = DIM_BITS'($urandom_range(0, band_rows));
            else if (pick < 70)
               row = DIM_BITS'(h_eff - 1 - int'($urandom_range(0, band_rows)));
            else if (pick < 85)
               row = DIM_BITS'($urandom_range(0, h_eff - 1));
            else if (pick < 93)
               row = DIM_BITS'(h_eff + int'($urandom_range(0, 3)));
            else
               row = DIM_BITS'($urandom);
            send_row(row);
         end
      end
      gap_max = 7;
      stall_max = 7;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_shape();
      test_register_extremes();
      test_narrow_spans();
      test_random_shapes();
      req_valid <= 1'b0;
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatches == 0 && expected_spans.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
